// File: hw/rtl/bit_crush_downsample_core_defines.svh
// Assertion macros shared by the checker of the bit crusher core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BIT_CRUSH_DOWNSAMPLE_CORE_DEFINES_SVH
`define BIT_CRUSH_DOWNSAMPLE_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bit crusher check failed");

// Next-cycle implication, checked while out of reset.
`define BCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bit crusher check failed");

`endif

// File: hw/rtl/bcd_pkg.sv
`timescale 1ns / 1ps
package bcd_pkg;

	// Resolution of the sample path; the cut depth is limited to one below it.
	localparam int SAMPLE_BITS = 32;
	localparam logic [5:0] CUT_LIM = 6'(SAMPLE_BITS - 1);

	// Configuration port geometry.
	localparam int ADDR_W = 4;

	// Register indexes (byte address bits [3:2]).
	localparam logic [1:0] REG_BIT_CUT        = 2'd0;
	localparam logic [1:0] REG_NUDGE_FRACTION = 2'd1;
	localparam logic [1:0] REG_REPEAT_AMOUNT  = 2'd2;

	// Offset-binary conversion and Q16.16 unity.
	localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
	localparam logic [31:0] CREDIT_ONE = 32'h0001_0000;

	// Settings that the crusher datapath needs.
	typedef struct packed {
		logic signed [5:0] bit_cut;
		logic [7:0]        nudge_fraction;
	} crush_cfg_t;

endpackage

// File: hw/rtl/bcd_crush.sv
`timescale 1ns / 1ps
module bcd_crush
	import bcd_pkg::*;
(
	input  crush_cfg_t         cfg,
	input  logic signed [31:0] sample,
	input  logic signed [15:0] noise,
	output logic signed [31:0] result
);

	logic               dith;
	logic [5:0]         mag;
	logic [4:0]         m;
	logic [4:0]         m_less;
	logic [31:0]        u;
	logic [31:0]        masked;
	logic signed [9:0]  gain;
	logic signed [25:0] dprod;
	logic signed [26:0] nudge;
	logic signed [26:0] step_sum;
	logic signed [57:0] step_sum_sh;
	logic signed [57:0] w;
	logic [57:0]        wr;
	logic [34:0]        r;
	logic [31:0]        rsat;

	// Cut depth: magnitude of the signed cut, limited to one below the sample resolution.
	assign dith   = cfg.bit_cut[5];
	assign mag    = dith ? (6'd0 - $unsigned(cfg.bit_cut)) : $unsigned(cfg.bit_cut);
	assign m      = (mag > CUT_LIM) ? CUT_LIM[4:0] : mag[4:0];
	assign m_less = m - 5'd1;

	// Offset-binary word with the low bits cleared.
	assign u      = sample ^ SIGN_BIT;
	assign masked = u & (32'hFFFF_FFFF << m);

	// The half step, dither and nudge all scale with half a step, so they are summed
	// in units of 2^(m-1) first and shifted once.
	assign gain     = 10'sd256 + $signed({2'b00, cfg.nudge_fraction});
	assign dprod    = gain * noise;
	assign nudge    = $signed({4'b0000, cfg.nudge_fraction, 15'b0});
	assign step_sum = 27'sd8388608 + (dith ? 27'(dprod) : 27'sd0) + (u[m] ? -nudge : nudge);

	assign step_sum_sh = 58'(step_sum) <<< m_less;
	assign w           = $signed({3'b000, masked, 23'b0}) + step_sum_sh;

	// Round to nearest with ties upward, clamp below zero and above full scale.
	assign wr   = $unsigned(w) + 58'd4194304;
	assign r    = w[57] ? 35'd0 : wr[57:23];
	assign rsat = (|r[34:32]) ? 32'hFFFF_FFFF : r[31:0];

	// A cut of zero passes the sample untouched.
	assign result = (mag == 6'd0) ? sample : $signed(rsat ^ SIGN_BIT);

endmodule

// File: hw/rtl/bit_crush_downsample_core.sv
`timescale 1ns / 1ps
// Bit crusher with sample-and-hold decimation.
// A word passes the input register, then the result register. Throughput: one word per
// cycle unless the output stalls, set by the input register feeding the crusher datapath
// (mask, one 10x16 multiply, shift and round) straight into the result register.
// Reset clears the word valids, the configuration registers, the held sample and the credit.
module bit_crush_downsample_core
	import bcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  sample_in,
	input  logic signed [15:0]  dither_noise,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  sample_out,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic signed [5:0]  bit_cut_q;
	logic [7:0]         nudge_fraction_q;
	logic [31:0]        repeat_amount_q;
	logic [31:0]        held_q;
	logic [31:0]        credit_q;

	logic               valid_s1;
	logic signed [31:0] sample_s1;
	logic signed [15:0] noise_s1;
	logic               use_held_s1;
	logic               hold_s1;

	logic               out_valid_q;
	logic signed [31:0] out_q;

	logic               cfg_wr;
	logic               slot_free;
	logic               advance;
	logic               accept;
	logic               use_held_in;
	logic [32:0]        credit_sum;
	crush_cfg_t         crush_cfg;
	logic signed [31:0] crushed;
	logic signed [31:0] result;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cut_q        <= '0;
			nudge_fraction_q <= '0;
			repeat_amount_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BIT_CUT:        bit_cut_q        <= $signed(pwdata[5:0]);
				REG_NUDGE_FRACTION: nudge_fraction_q <= pwdata[7:0];
				REG_REPEAT_AMOUNT:  repeat_amount_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BIT_CUT:        prdata = {26'b0, $unsigned(bit_cut_q)};
			REG_NUDGE_FRACTION: prdata = {24'b0, nudge_fraction_q};
			REG_REPEAT_AMOUNT:  prdata = repeat_amount_q;
			default:            prdata = '0;
		endcase
	end

	// Handshake: the input stage moves on whenever the result register is free.
	assign slot_free = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && slot_free;
	assign in_stall  = valid_s1 && !slot_free;
	assign accept    = in_valid && !in_stall;

	// Decimation decision is made at acceptance; the credit only depends on earlier words.
	assign use_held_in = (repeat_amount_q != 32'd0) && (credit_q >= CREDIT_ONE);
	assign credit_sum  = {1'b0, credit_q} + {1'b0, repeat_amount_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && repeat_amount_q != 32'd0) begin
			if (use_held_in) begin
				credit_q <= credit_q - CREDIT_ONE;
			end else begin
				credit_q <= credit_sum[32] ? 32'hFFFF_FFFF : credit_sum[31:0];
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample_in;
			noise_s1    <= dither_noise;
			use_held_s1 <= use_held_in;
			hold_s1     <= (repeat_amount_q != 32'd0) && !use_held_in;
		end
	end

	// Crusher datapath.
	assign crush_cfg.bit_cut        = bit_cut_q;
	assign crush_cfg.nudge_fraction = nudge_fraction_q;

	bcd_crush u_crush (
		.cfg    (crush_cfg),
		.sample (sample_s1),
		.noise  (noise_s1),
		.result (crushed)
	);

	// Words leave in order, so the held sample is current when a repeat reaches here.
	assign result = use_held_s1 ? $signed(held_q) : crushed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance && hold_s1) begin
			held_q <= $unsigned(result);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

// File: hw/rtl/bcd_checker.sv
`timescale 1ns / 1ps
`include "bit_crush_downsample_core_defines.svh"
module bcd_checker
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic signed [31:0]  sample_out,
	input logic                psel,
	input logic                pready
);

	// A stalled result word stays put.
	`BCD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample_out))

	// The input side only stalls when the result word is backed up.
	`BCD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// An accepted word passes through the input register to the output when the output is not stalled.
	`BCD_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid)

	// The configuration port never inserts wait states.
	`BCD_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind bit_crush_downsample_core bcd_checker u_bcd_checker (.*);

// File: bench/crush_hold_checker.sv
`timescale 1ns / 1ps
module crush_hold_checker
	import bcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] sample_in,
	input  logic signed [15:0] dither_noise,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] sample_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 words_pending
);

	// Shadow copy of the settings and of the sample-and-hold state.
	logic [5:0]  cut_cfg;
	logic [7:0]  nudge_cfg;
	logic [31:0] repeat_cfg;
	logic [31:0] held_word;
	logic [31:0] credit;
	logic [31:0] expected_words[$];
	int          fail_tally;

	// Crushed value of one sample: mask, half step and dither, nudge, round and saturate.
	function automatic logic [31:0] crush_word(input logic [31:0] s, input logic [15:0] noise,
			input logic [5:0] cut, input logic [7:0] nf);
		logic        dith;
		int          m;
		logic [31:0] masked;
		longint      w;
		longint      gain;
		longint      r;
		dith = cut[5];
		m = dith ? 64 - int'(cut) : int'(cut);
		if (m == 0)
			return s;
		if (m > int'(CUT_LIM))
			m = int'(CUT_LIM);
		masked = (s ^ SIGN_BIT) & (32'hFFFF_FFFF << m);
		w = longint'({32'd0, masked}) << 23;
		w += 64'sd1 << (m + 22);
		gain = longint'({24'd0, nf}) + 256;
		// Dither adds noise, scaled to the half step, on top of the fixed half step.
		if (dith) begin
			w += (gain * longint'({48'd0, noise ^ 16'h8000})) << (m - 1);
			w -= gain << (m + 14);
		end
		// The nudge direction follows the lowest kept bit.
		if (nf != 8'd0) begin
			if (masked[m])
				w -= longint'({56'd0, nf}) << (m + 14);
			else
				w += longint'({56'd0, nf}) << (m + 14);
		end
		if (w < 0)
			w = 0;
		r = (w + (64'sd1 << 22)) >> 23;
		if (r > 64'sh0000_0000_FFFF_FFFF)
			r = 64'sh0000_0000_FFFF_FFFF;
		return r[31:0] ^ SIGN_BIT;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [31:0] want;
		logic [32:0] credit_sum;
		if (!arst_n) begin
			cut_cfg = '0;
			nudge_cfg = '0;
			repeat_cfg = '0;
			held_word = '0;
			credit = '0;
			expected_words.delete();
			fail_tally = 0;
			mismatches <= 0;
			words_pending <= 0;
		end else begin
			// A delivered word is checked against the oldest expected word.
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10)
						$display("%0t: sample_out %h arrived with no word expected", $time,
							sample_out);
				end else begin
					want = expected_words.pop_front();
					if (sample_out !== want) begin
						fail_tally++;
						if (fail_tally <= 10)
							$display("%0t: sample_out mismatch: expected %h, got %h", $time,
								want, sample_out);
					end
				end
			end

			// An accepted word either is crushed or repeats the held one.
			if (in_valid && !in_stall) begin
				if (repeat_cfg == 32'd0) begin
					want = crush_word(sample_in, dither_noise, cut_cfg, nudge_cfg);
				end else if (credit >= CREDIT_ONE) begin
					want = held_word;
					credit = credit - CREDIT_ONE;
				end else begin
					want = crush_word(sample_in, dither_noise, cut_cfg, nudge_cfg);
					held_word = want;
					credit_sum = {1'b0, credit} + {1'b0, repeat_cfg};
					credit = credit_sum[32] ? 32'hFFFF_FFFF : credit_sum[31:0];
				end
				expected_words.push_back(want);
			end

			// Register writes on the configuration port.
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_BIT_CUT: begin
						cut_cfg = pwdata[5:0];
					end
					REG_NUDGE_FRACTION: begin
						nudge_cfg = pwdata[7:0];
					end
					REG_REPEAT_AMOUNT: begin
						repeat_cfg = pwdata;
					end
					default: begin
					end
				endcase
			end

			mismatches <= fail_tally;
			words_pending <= expected_words.size();
		end
	end

endmodule

// File: bench/bit_crush_downsample_core_tb.sv
`timescale 1ns / 1ps
module bit_crush_downsample_core_tb;
	import bcd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS = 160;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] sample_in;
	logic signed [15:0] dither_noise;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] sample_out;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int mismatches;
	int words_pending;
	int send_idle_pct = 27;
	int recv_idle_pct = 88;
	int hold_requests = 0;
	int cycles = 0;

	bit_crush_downsample_core dut (.*);

	crush_hold_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Setup and access cycle of one register write; called at a falling edge.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apply_settings(input logic [5:0] cut, input logic [7:0] nf,
			input logic [31:0] repeat_amt);
		reg_write(REG_BIT_CUT, {26'd0, cut});
		reg_write(REG_NUDGE_FRACTION, {24'd0, nf});
		reg_write(REG_REPEAT_AMOUNT, repeat_amt);
	endtask

	// Offer one word and hold it until accepted; starts and ends at a falling edge.
	task automatic send_word(input logic [31:0] s, input logic [15:0] d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample_in = s;
		dither_noise = d;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected word has been delivered.
	task automatic drain();
		in_valid = 1'b0;
		while (words_pending != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 511)) - 32'd256;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_noise();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [5:0] pick_cut();
		case ($urandom_range(0, 5))
			0: return 6'd0;
			1: return 6'd31;
			2: return 6'b100000;
			3: return 6'b100001;
			default: return 6'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_nudge();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Repeat amounts stay small so that the credit never outlasts a phase.
	function automatic logic [31:0] pick_repeat();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return CREDIT_ONE;
			2: return 32'h0000_FFFF;
			default: return $urandom_range(0, 32'h0004_FFFF);
		endcase
	endfunction

	initial begin
		in_valid = 1'b0;
		sample_in = '0;
		dither_noise = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bypass with the reset settings.
		send_word(32'h7FFF_FFFF, 16'h7FFF);
		send_word(32'h8000_0000, 16'h8000);
		send_word(32'h0000_0000, 16'h0000);
		send_word(32'hFFFF_FFFF, 16'hFFFF);
		drain();

		// Deepest plain mask with the largest nudge.
		apply_settings(6'd31, 8'd255, 32'd0);
		send_word(32'h7FFF_FFFF, 16'h0000);
		send_word(32'h8000_0000, 16'h0000);
		send_word(32'h1234_5678, 16'h0000);
		drain();

		// Dither at a cut of minus 32, read as 31.
		apply_settings(6'b100000, 8'd255, 32'd0);
		send_word(32'h8000_0000, 16'h8000);
		send_word(32'h7FFF_FFFF, 16'h7FFF);
		send_word(32'h0000_0000, 16'h0000);
		send_word(32'h7FFF_FFFF, 16'h8000);
		drain();

		// Single-bit dither with a repeat amount of one and a half.
		apply_settings(6'b111111, 8'd0, 32'h0001_8000);
		send_word(32'h4000_0001, 16'h1234);
		send_word(32'hC000_0000, 16'hEDCB);
		send_word(32'h0000_0001, 16'h7FFF);
		send_word(32'hFFFF_FFFE, 16'h8000);
		send_word(32'h5555_5555, 16'h0001);
		send_word(32'hAAAA_AAAA, 16'hFFFE);
		drain();

		// Dither at minus 31 with the smallest nudge and a larger repeat.
		apply_settings(6'b100001, 8'd1, 32'h0002_4000);
		send_word(32'h8000_0000, 16'h0000);
		send_word(32'h7FFF_FFFF, 16'h0000);
		send_word(32'h0F0F_0F0F, 16'h8000);
		send_word(32'hF0F0_F0F0, 16'h7FFF);
		drain();

		// Random phases: receiver stalls first, then sender idles, then neither.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < RANDOM_PHASES / 3) begin
				send_idle_pct = 27;
				recv_idle_pct = 88;
			end else if (p < 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 88;
				recv_idle_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain();
			// The last phase saturates the credit, which then holds for good.
			if (p == RANDOM_PHASES - 1)
				apply_settings(pick_cut(), pick_nudge(), 32'hFFFF_FFFF);
			else
				apply_settings(pick_cut(), pick_nudge(), pick_repeat());
			if (p == RANDOM_PHASES - 3)
				hold_requests++;
			repeat (PHASE_WORDS)
				send_word(pick_sample(), pick_noise());
		end
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
